@@ hw/rtl/fdem_pkg.sv @@
// Shared widths, register codes and queue types of the forward-difference edge map.
`default_nettype none
package fdem_pkg;

  localparam int PIX_W       = 16;
  localparam int EDGE_W      = 17;
  localparam int ROW_W       = 16;
  localparam int COL_OUT_W   = 10;
  localparam int WIDTH_REG_W = 11;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [WIDTH_REG_W-1:0] WIDTH_RESET  = 11'd1024;
  localparam logic [ROW_W-1:0]       HEIGHT_RESET = 16'd1024;

  // One classified pixel: up to two results, the one for the row above first.
  typedef struct packed {
    logic                 has_above;
    logic                 has_self;
    logic                 last;
    logic [EDGE_W-1:0]    edge_above;
    logic [PIX_W-1:0]     self_value;
    logic [ROW_W-1:0]     row;
    logic [COL_OUT_W-1:0] column;
  } fdem_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fdem_q_status_t;

endpackage
`default_nettype wire

@@ hw/rtl/fdem_pix_if.sv @@
// Pixel input channel: valid/ready handshake with one grey level per word.
`default_nettype none
interface fdem_pix_if;
  import fdem_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink (input valid, input pixel_value, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/fdem_edge_if.sv @@
// Edge map output channel: valid/ready handshake with value, position and end mark.
`default_nettype none
interface fdem_edge_if;
  import fdem_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [EDGE_W-1:0]    edge_value;
  logic [ROW_W-1:0]     out_row;
  logic [COL_OUT_W-1:0] out_column;
  logic                 last_of_image;

  modport source (output valid, output edge_value, output out_row, output out_column,
                  output last_of_image, input ready);
  modport sink (input valid, input edge_value, input out_row, input out_column,
                input last_of_image, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/fdem_front.sv @@
// Front end: configuration, raster counters, line buffer and difference computation.
`default_nettype none
module fdem_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            cfg_write,
  input  wire  [fdem_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  [fdem_pkg::CFG_W-1:0]     cfg_data,
  fdem_pix_if.sink                       pixels,
  output logic                           q_push,
  output fdem_pkg::fdem_entry_t          q_data,
  input  wire  fdem_pkg::fdem_q_status_t q_stat
);
  import fdem_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [WIDTH_REG_W-1:0] image_width;
  logic [ROW_W-1:0]       image_height;
  logic [CW-1:0]          col;
  logic [CW-1:0]          col_inc;
  logic [ROW_W-1:0]       row;

  logic [PIXEL_BITS-1:0]  line_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0]  rd_here;
  logic [PIXEL_BITS-1:0]  rd_right;

  logic                   s1_valid;
  logic [PIXEL_BITS-1:0]  s1_pix;
  logic [ROW_W-1:0]       s1_row;
  logic [CW-1:0]          s1_col;
  logic                   s1_has_above;
  logic                   s1_last_col;
  logic                   s1_last_row;

  logic                   accept;
  logic                   s1_drain;
  logic                   last_col;
  logic                   last_row;
  logic [PIXEL_BITS-1:0]  pix;
  logic [PIXEL_BITS-1:0]  gap_down;
  logic [PIXEL_BITS-1:0]  gap_right;
  logic [EDGE_W-1:0]      edge_sum;

  assign pix     = pixels.pixel_value[PIXEL_BITS-1:0];
  assign col_inc = col + CW'(1);

  // A zero register acts as one; a width beyond the buffer acts as the buffer size.
  assign last_col = (image_width == '0) ||
                    (32'(col) + 32'd1 >= 32'(image_width)) ||
                    (32'(col) + 32'd1 >= 32'(MAX_WIDTH));
  assign last_row = (image_height == '0) ||
                    (32'(row) + 32'd1 >= 32'(image_height));

  assign s1_drain     = s1_valid && (!(s1_has_above || s1_last_row) || !q_stat.full);
  assign pixels.ready = !s1_valid || s1_drain;
  assign accept       = pixels.valid && pixels.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : row + ROW_W'(1);
      end else begin
        col <= col_inc;
      end
    end
  end

  // Both reads see the previous row: the write to the same column lands after them.
  always_ff @(posedge clk) begin
    if (accept) begin
      line_mem[col] <= pix;
      rd_here       <= line_mem[col];
      rd_right      <= line_mem[col_inc];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_drain) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix       <= pix;
      s1_row       <= row;
      s1_col       <= col;
      s1_has_above <= (row != '0);
      s1_last_col  <= last_col;
      s1_last_row  <= last_row;
    end
  end

  assign gap_down  = (s1_pix > rd_here) ? s1_pix - rd_here : rd_here - s1_pix;
  assign gap_right = (rd_right > rd_here) ? rd_right - rd_here : rd_here - rd_right;
  assign edge_sum  = s1_last_col ? EDGE_W'(rd_here)
                                 : EDGE_W'(gap_down) + EDGE_W'(gap_right);

  // Pixels of the first row of a taller image give no word and skip the queue.
  assign q_push = s1_drain && (s1_has_above || s1_last_row);

  always_comb begin
    q_data            = '0;
    q_data.has_above  = s1_has_above;
    q_data.has_self   = s1_last_row;
    q_data.last       = s1_last_row && s1_last_col;
    q_data.edge_above = edge_sum;
    q_data.self_value = PIX_W'(s1_pix);
    q_data.row        = s1_row;
    q_data.column     = COL_OUT_W'(s1_col);
  end

endmodule
`default_nettype wire

@@ hw/rtl/fdem_fifo.sv @@
// Short queue of classified pixels between the front and back ends.
`default_nettype none
module fdem_fifo (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            push,
  input  wire  fdem_pkg::fdem_entry_t    push_data,
  input  wire                            pop,
  output fdem_pkg::fdem_entry_t          head,
  output fdem_pkg::fdem_q_status_t       stat
);
  import fdem_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  fdem_entry_t      slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign stat.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/fdem_back.sv @@
// Back end: splits each queued pixel into its result words and drives the output register.
`default_nettype none
module fdem_back (
  input  wire                            clk,
  input  wire                            rst,
  input  wire  fdem_pkg::fdem_entry_t    head,
  input  wire  fdem_pkg::fdem_q_status_t q_stat,
  output logic                           q_pop,
  fdem_edge_if.source                    edges
);
  import fdem_pkg::*;

  logic                 out_valid;
  logic [EDGE_W-1:0]    out_edge;
  logic [ROW_W-1:0]     out_row_q;
  logic [COL_OUT_W-1:0] out_col_q;
  logic                 out_last;
  logic                 first_done;

  logic                 load;
  logic                 emit_above;

  assign load       = (!out_valid || edges.ready) && !q_stat.empty;
  assign emit_above = head.has_above && !first_done;
  // An entry with both words stays at the head until its second word is loaded into the output register.
  assign q_pop      = load && !(emit_above && head.has_self);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      first_done <= 1'b0;
    end else begin
      if (load) begin
        out_valid  <= 1'b1;
        first_done <= emit_above && head.has_self;
      end else if (edges.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_col_q <= head.column;
      if (emit_above) begin
        out_edge  <= head.edge_above;
        out_row_q <= head.row - ROW_W'(1);
        out_last  <= 1'b0;
      end else begin
        out_edge  <= EDGE_W'(head.self_value);
        out_row_q <= head.row;
        out_last  <= head.last;
      end
    end
  end

  assign edges.valid         = out_valid;
  assign edges.edge_value    = out_edge;
  assign edges.out_row       = out_row_q;
  assign edges.out_column    = out_col_q;
  assign edges.last_of_image = out_last;

endmodule
`default_nettype wire

@@ hw/rtl/forward_difference_edge_map_top.sv @@
// Top level of the forward-difference edge map: front end, queue and back end.
//
//   channel   dir  handshake      word
//   pixels    in   valid/ready    pixel_value[15:0]
//   edges     out  valid/ready    edge_value[16:0], out_row, out_column, last_of_image
//   cfg       in   cfg_write      cfg_index, cfg_data[15:0] (width, height)
//
// One pixel is taken per clock while pixels.ready is high. Rows before the last give at
// most one word per pixel (the first row none), so they stream at one pixel per cycle
// while edges.ready holds; the last row of a taller image gives two words per pixel and
// the single output register then sets the pace.
// Each word is held in the stage-1 registers, a queue slot and then the output register.
// Reset (rst, synchronous) clears counters, queue and valid flags and loads the
// register defaults; the line buffer is not cleared and needs no pass after reset.
// Output stalls fill the four-entry queue before pixels.ready drops.
`default_nettype none
module forward_difference_edge_map_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            cfg_write,
  input  wire  [fdem_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire  [fdem_pkg::CFG_W-1:0]     cfg_data,
  fdem_pix_if.sink                       pixels,
  fdem_edge_if.source                    edges
);
  import fdem_pkg::*;

  logic           q_push;
  logic           q_pop;
  fdem_entry_t    q_data;
  fdem_entry_t    q_head;
  fdem_q_status_t q_stat;

  fdem_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixels    (pixels),
    .q_push    (q_push),
    .q_data    (q_data),
    .q_stat    (q_stat)
  );

  fdem_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  fdem_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (q_head),
    .q_stat (q_stat),
    .q_pop  (q_pop),
    .edges  (edges)
  );

  // The front end must never push into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("queue written while full");

  // The back end must never take a word from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("queue read while empty");

  // Every queued entry carries at least one result word.
  a_entry_has_word: assert property (@(posedge clk) disable iff (rst)
    q_push |-> (q_data.has_above || q_data.has_self))
    else $error("queued entry carries no word");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !edges.valid)
    else $error("output word present right after reset");

endmodule
`default_nettype wire
